### rtl/core/ptrm_pkg.sv
// shared constants, types and helpers of the pixel tint and row mirror block
package ptrm_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int COL_W           = $clog2(MAX_WIDTH);
    localparam int ADDR_W          = $clog2(2 * MAX_WIDTH);
    localparam int DEPTH           = 2 * MAX_WIDTH;
    localparam int CFG_W           = 11;
    localparam int CHAN_W          = 8;
    localparam int PIX_W           = 3 * CHAN_W;
    localparam int RESET_ROW_WIDTH = 1024;
    localparam int ROW_MOD         = 7;
    localparam int COL_MOD         = 9;
    localparam int ROW_MOD_W       = $clog2(ROW_MOD);
    localparam int COL_MOD_W       = $clog2(COL_MOD);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_IDLE  = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [ADDR_W-1:0] line_addr(input logic bank,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(col) + (bank ? ADDR_W'(MAX_WIDTH) : ADDR_W'(0));
    endfunction

endpackage

### rtl/core/ptrm_line_ram.sv
// ping-pong line buffer memory, one write and one registered read port
module ptrm_line_ram
(
    input  logic                      clk,
    input  ptrm_pkg::ram_req_t        req,
    output logic [ptrm_pkg::PIX_W-1:0] rdata
);

    logic [ptrm_pkg::PIX_W-1:0] mem [ptrm_pkg::DEPTH];
    logic [ptrm_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ptrm_ctrl.sv
// row and column tracking, tint and line buffer addressing
module ptrm_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [ptrm_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        accept,
    input  logic                        cmd,
    input  logic                        frame_start,
    input  logic [ptrm_pkg::CHAN_W-1:0] red,
    input  logic [ptrm_pkg::CHAN_W-1:0] green,
    input  logic [ptrm_pkg::CHAN_W-1:0] blue,
    output ptrm_pkg::ram_req_t          req,
    output logic                        rd_last
);

    localparam int COL_W = ptrm_pkg::COL_W;
    localparam int RW    = ptrm_pkg::ROW_MOD_W;
    localparam int CW    = ptrm_pkg::COL_MOD_W;
    localparam int CH    = ptrm_pkg::CHAN_W;

    function automatic logic [COL_W-1:0] eff_last(input logic [ptrm_pkg::CFG_W-1:0] w);
        logic [COL_W-1:0] res;
        if (w == '0)
        begin
            res = '0;
        end
        else if (32'(w) > ptrm_pkg::MAX_WIDTH)
        begin
            res = COL_W'(ptrm_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            res = COL_W'(w - ptrm_pkg::CFG_W'(1));
        end
        return res;
    endfunction

    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [COL_W-1:0] write_col_reg, write_col_next;
    logic [COL_W-1:0] read_col_reg, read_col_next;
    logic             write_bank_reg, write_bank_next;
    logic             pending_reg, pending_next;
    logic [RW-1:0]    row_mod_reg, row_mod_next;
    logic [CW-1:0]    col_mod_reg, col_mod_next;

    logic [COL_W-1:0] rc;
    logic [COL_W-1:0] wc0;
    logic [COL_W-1:0] wc;
    logic [RW-1:0]    rm;
    logic [CW-1:0]    cm;
    logic             emit;
    logic             pix;
    logic [CH-1:0]    blue_t;
    logic [CH:0]      red_sum;
    logic [CH-1:0]    red_t;

    always_comb
    begin
        emit    = accept && pending_reg;
        pix     = accept && (cmd == ptrm_pkg::CMD_PIXEL);
        rc      = (read_col_reg > last_col_reg) ? last_col_reg : read_col_reg;
        rd_last = (rc == last_col_reg);

        wc0 = frame_start ? '0 : write_col_reg;
        cm  = frame_start ? '0 : col_mod_reg;
        rm  = frame_start ? '0 : row_mod_reg;
        wc  = (wc0 > last_col_reg) ? last_col_reg : wc0;

        blue_t  = (blue >= CH'(rm)) ? blue - CH'(rm) : '0;
        red_sum = {1'b0, red} + (CH + 1)'(cm);
        red_t   = red_sum[CH] ? {CH{1'b1}} : red_sum[CH-1:0];

        req.re    = emit;
        req.raddr = ptrm_pkg::line_addr(~write_bank_reg, last_col_reg - rc);
        req.we    = pix;
        req.waddr = ptrm_pkg::line_addr(write_bank_reg, wc);
        req.wdata = {red_t, green, blue_t};
    end

    always_comb
    begin
        last_col_next   = cfg_valid ? eff_last(cfg_data) : last_col_reg;
        write_col_next  = write_col_reg;
        read_col_next   = read_col_reg;
        write_bank_next = write_bank_reg;
        pending_next    = pending_reg;
        row_mod_next    = row_mod_reg;
        col_mod_next    = col_mod_reg;

        if (emit)
        begin
            if (rd_last)
            begin
                pending_next  = 1'b0;
                read_col_next = '0;
            end
            else
            begin
                read_col_next = rc + COL_W'(1);
            end
        end

        if (pix)
        begin
            if (wc == last_col_reg)
            begin
                write_bank_next = ~write_bank_reg;
                pending_next    = 1'b1;
                read_col_next   = '0;
                write_col_next  = '0;
                col_mod_next    = '0;
                row_mod_next    = (rm == RW'(ptrm_pkg::ROW_MOD - 1)) ? '0 : rm + RW'(1);
            end
            else
            begin
                write_col_next = wc + COL_W'(1);
                col_mod_next   = (cm == CW'(ptrm_pkg::COL_MOD - 1)) ? '0 : cm + CW'(1);
                row_mod_next   = rm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg   <= eff_last(ptrm_pkg::CFG_W'(ptrm_pkg::RESET_ROW_WIDTH));
            write_col_reg  <= '0;
            read_col_reg   <= '0;
            write_bank_reg <= 1'b0;
            pending_reg    <= 1'b0;
            row_mod_reg    <= '0;
            col_mod_reg    <= '0;
        end
        else
        begin
            last_col_reg   <= last_col_next;
            write_col_reg  <= write_col_next;
            read_col_reg   <= read_col_next;
            write_bank_reg <= write_bank_next;
            pending_reg    <= pending_next;
            row_mod_reg    <= row_mod_next;
            col_mod_reg    <= col_mod_next;
        end
    end

endmodule

### rtl/core/ptrm_out.sv
// read data holding slot and output register with backpressure
module ptrm_out
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_fire,
    input  logic                       rd_last,
    input  logic [ptrm_pkg::PIX_W-1:0] rd_data,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [ptrm_pkg::PIX_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       space
);

    logic                       rd_valid_reg, rd_valid_next;
    logic                       rd_last_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [ptrm_pkg::PIX_W-1:0] out_data_reg;
    logic                       out_last_reg;
    logic                       move;

    always_comb
    begin
        move  = rd_valid_reg && (!out_valid_reg || m_tready);
        space = !rd_valid_reg || !out_valid_reg || m_tready;

        rd_valid_next = rd_fire ? 1'b1 : (move ? 1'b0 : rd_valid_reg);

        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            rd_last_reg <= rd_last;
        end
        if (move)
        begin
            out_data_reg <= rd_data;
            out_last_reg <= rd_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[7:0], out_data_reg[15:8], out_data_reg[23:16]};
    assign m_tlast  = out_last_reg;

endmodule

### rtl/core/pixel_tint_and_row_mirror.sv
// top level of the pixel tint and row mirror block
// One item is taken per clock, sustained, while the output side keeps up. A pixel item
// is tinted and written into the ping-pong line buffer in the cycle it is taken; an item
// taken while a completed row is pending also reads one mirrored pixel, which reaches
// the master side through the registered memory read and then the output register. A
// two-deep output (read slot plus output register) lets input keep flowing while the
// read slot is free during an output stall; s_tready drops only when both hold a pixel and
// m_tready is low. The line buffer is not cleared after reset, so rows are mirrored only
// once written; row_width may be changed only while the block is idle and takes effect
// at once for later items.
module pixel_tint_and_row_mirror
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic [1:0]  s_tuser,   // cmd, frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    ptrm_pkg::ram_req_t         req;
    logic [ptrm_pkg::PIX_W-1:0] rd_data;
    logic                       rd_last;
    logic                       space;
    logic                       accept;

    assign s_tready  = space;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && space;

    ptrm_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .cmd         (s_tuser[0]),
        .frame_start (s_tuser[1]),
        .red         (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .blue        (s_tdata[23:16]),
        .req         (req),
        .rd_last     (rd_last)
    );

    ptrm_line_ram u_ram
    (
        .clk   (clk),
        .req   (req),
        .rdata (rd_data)
    );

    ptrm_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_fire  (req.re),
        .rd_last  (rd_last),
        .rd_data  (rd_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .space    (space)
    );

endmodule

### rtl/core/ptrm_checker.sv
// port level checks of the pixel tint and row mirror block
module ptrm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // output held under stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed under stall");

    // input stalls only behind a stalled full output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // a fresh output item follows an accepted item through the read slot and output register
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output item without an accepted item");

endmodule

bind pixel_tint_and_row_mirror ptrm_checker u_ptrm_checker (.*);

### dv/pixel_tint_and_row_mirror_test.sv
// self-checking testbench for the pixel tint and row mirror block
`timescale 1ns / 100ps

module pixel_tint_and_row_mirror_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int SUBPHASE_ITEMS = 65;
    localparam int PARTIAL_ITEMS  = 20;

    typedef struct packed {
        logic        cmd;
        logic        frame_start;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eor;
    } mirror_px_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // red, green, blue
    logic [1:0]  s_tuser = '0;     // cmd, frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // out_red, out_green, out_blue
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    pixel_item_t pixel_q[$];
    mirror_px_t  mirrored_q[$];
    pixel_item_t drv_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;

    // predictor state
    rgb_t        line_mem [2*ptrm_pkg::MAX_WIDTH];
    logic [10:0] row_width_q = 11'(ptrm_pkg::RESET_ROW_WIDTH);
    int unsigned wr_col = 0;
    int unsigned rd_col = 0;
    logic        wr_bank = 1'b0;
    logic        row_pending_q = 1'b0;
    int unsigned tint_row = 0;
    int unsigned tint_col = 0;

    pixel_tint_and_row_mirror dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_width(input logic [10:0] raw);
        if (raw == 0)
            return 1;
        if (raw > ptrm_pkg::MAX_WIDTH)
            return ptrm_pkg::MAX_WIDTH;
        return 32'(raw);
    endfunction

    task automatic tint_and_mirror(input pixel_item_t it);
        int unsigned w;
        rgb_t        px;
        mirror_px_t  res;
        logic [8:0]  red_sum;
        logic [10:0] addr;
        w = eff_width(row_width_q);
        if (row_pending_q)
        begin
            if (rd_col >= w)
                rd_col = w - 1;
            addr = 11'((wr_bank ? 0 : ptrm_pkg::MAX_WIDTH) + (w - 1 - rd_col));
            px = line_mem[addr];
            res.red   = px.red;
            res.green = px.green;
            res.blue  = px.blue;
            res.eor   = (rd_col + 1 >= w);
            mirrored_q.push_back(res);
            if (res.eor)
            begin
                row_pending_q = 1'b0;
                rd_col = 0;
            end
            else
                rd_col++;
        end
        if (it.cmd == ptrm_pkg::CMD_IDLE)
            return;
        if (it.frame_start)
        begin
            wr_col = 0;
            tint_col = 0;
            tint_row = 0;
        end
        if (wr_col >= w)
            wr_col = w - 1;
        px.blue  = (it.blue >= tint_row) ? 8'(it.blue - tint_row) : 8'd0;
        red_sum  = 9'(it.red + tint_col);
        px.red   = (red_sum > 255) ? 8'hFF : red_sum[7:0];
        px.green = it.green;
        addr = 11'((wr_bank ? ptrm_pkg::MAX_WIDTH : 0) + wr_col);
        line_mem[addr] = px;
        if (wr_col + 1 >= w)
        begin
            wr_bank = ~wr_bank;
            row_pending_q = 1'b1;
            rd_col = 0;
            wr_col = 0;
            tint_col = 0;
            tint_row = (tint_row + 1 >= ptrm_pkg::ROW_MOD) ? 0 : tint_row + 1;
        end
        else
        begin
            wr_col++;
            tint_col = (tint_col + 1 >= ptrm_pkg::COL_MOD) ? 0 : tint_col + 1;
        end
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(7));
            1:       return 8'($urandom_range(255, 246));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_pixel(input logic fs, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b);
        pixel_item_t it;
        it.cmd = ptrm_pkg::CMD_PIXEL;
        it.frame_start = fs;
        it.red = r;
        it.green = g;
        it.blue = b;
        pixel_q.push_back(it);
    endfunction

    function automatic void push_tick(input logic fs);
        pixel_item_t it;
        it.cmd = ptrm_pkg::CMD_IDLE;
        it.frame_start = fs;
        it.red = 8'($urandom_range(255));
        it.green = 8'($urandom_range(255));
        it.blue = 8'($urandom_range(255));
        pixel_q.push_back(it);
    endfunction

    // frames of rows with random content, the last row sometimes cut short, a little noise mixed in
    task automatic push_frames(input int n_items, input int max_rows);
        int unsigned w;
        int          pushed;
        int          rows;
        int          cut;
        int unsigned roll;
        w = eff_width(row_width_q);
        pushed = 0;
        while (pushed < n_items)
        begin
            rows = $urandom_range(max_rows, 1);
            cut = ($urandom_range(9) == 0) ? $urandom_range(w - 1) : w;
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < ((r == rows - 1) ? cut : w); c++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 4)
                    begin
                        push_tick(1'($urandom_range(1)));
                        pushed++;
                    end
                    push_pixel((r == 0 && c == 0) || (roll >= 4 && roll < 6),
                               pick_channel(), 8'($urandom_range(255)), pick_channel());
                    pushed++;
                end
            end
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || s_tvalid || mirrored_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic drain_pending();
        settle();
        if (row_pending_q)
        begin
            repeat (eff_width(row_width_q)) push_tick(1'($urandom_range(1)));
            settle();
        end
    endtask

    task automatic set_row_width(input logic [10:0] raw);
        settle();
        // a wider readout of a pending row would touch entries never written
        if (row_pending_q && eff_width(raw) > eff_width(row_width_q))
            drain_pending();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= raw;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        row_width_q = raw;
    endtask

    task automatic run_subphases(input logic [10:0] w0, input logic [10:0] w1,
                                 input logic [10:0] w2, input logic [10:0] w3,
                                 input logic [10:0] w4);
        logic [10:0] widths [5];
        widths = '{w0, w1, w2, w3, w4};
        foreach (widths[i])
        begin
            set_row_width(widths[i]);
            push_frames(SUBPHASE_ITEMS, 9);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                tint_and_mirror(drv_item);
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {drv_item.blue, drv_item.green, drv_item.red};
                s_tuser <= {drv_item.frame_start, drv_item.cmd};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        mirror_px_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (mirrored_q.size() == 0)
                begin
                    $error("unexpected mirrored item: tdata %h tlast %b", m_tdata, m_tlast);
                    err_count++;
                end
                else
                begin
                    want = mirrored_q.pop_front();
                    if (m_tdata[7:0] !== want.red)
                    begin
                        $error("out_red: expected %0d, actual %0d", want.red, m_tdata[7:0]);
                        err_count++;
                    end
                    if (m_tdata[15:8] !== want.green)
                    begin
                        $error("out_green: expected %0d, actual %0d", want.green,
                               m_tdata[15:8]);
                        err_count++;
                    end
                    if (m_tdata[23:16] !== want.blue)
                    begin
                        $error("out_blue: expected %0d, actual %0d", want.blue,
                               m_tdata[23:16]);
                        err_count++;
                    end
                    if (m_tlast !== want.eor)
                    begin
                        $error("end_of_row: expected %0d, actual %0d", want.eor, m_tlast);
                        err_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("pixel_tint_and_row_mirror verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_row_width(11'd3);
        push_pixel(1'b1, 8'd0, 8'h00, 8'd0);
        push_pixel(1'b0, 8'd255, 8'hFF, 8'd255);
        push_pixel(1'b0, 8'd254, 8'h5A, 8'hA5);
        push_pixel(1'b0, 8'd0, 8'hC3, 8'd0);
        // both channels clamp on the same pixel
        push_pixel(1'b0, 8'd255, 8'h3C, 8'd0);
        push_pixel(1'b0, 8'd100, 8'h0F, 8'd1);
        push_tick(1'b1);
        push_pixel(1'b1, 8'd200, 8'hF0, 8'd200);
        push_pixel(1'b0, 8'd255, 8'h01, 8'd2);
        push_tick(1'b0);
        push_pixel(1'b1, 8'd128, 8'h80, 8'd128);
        push_pixel(1'b0, 8'd250, 8'h7F, 8'd3);
        push_pixel(1'b0, 8'd247, 8'hFE, 8'd7);
        push_tick(1'b0);
        // shrink while a row is still draining
        set_row_width(11'd1);
        push_tick(1'b0);
        push_tick(1'b0);
        push_pixel(1'b1, 8'd255, 8'hAA, 8'd0);
        push_pixel(1'b0, 8'd1, 8'h55, 8'd255);
        push_tick(1'b0);
        push_tick(1'b1);
        set_row_width(11'd0);
        push_pixel(1'b0, 8'd255, 8'h00, 8'd0);
        push_pixel(1'b1, 8'd0, 8'hFF, 8'd255);
        push_tick(1'b0);

        send_idle_pct = 38;
        recv_stall_pct = 73;
        run_subphases(11'd2, 11'd9, 11'd0, 11'd5, 11'd16);

        send_idle_pct = 73;
        recv_stall_pct = 38;
        run_subphases(11'd1, 11'd7, 11'd3, 11'd10, 11'd12);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        // partial row at an oversized width, then a narrower row past its end
        set_row_width(11'd2047);
        push_pixel(1'b1, pick_channel(), 8'($urandom_range(255)), pick_channel());
        repeat (PARTIAL_ITEMS - 1)
            push_pixel(1'b0, pick_channel(), 8'($urandom_range(255)), pick_channel());
        set_row_width(11'd8);
        push_pixel(1'b0, pick_channel(), 8'($urandom_range(255)), pick_channel());
        run_subphases(11'd8, 11'd4, 11'd1, 11'd6, 11'd20);

        drain_pending();
        if (err_count == 0)
            $display("pixel_tint_and_row_mirror verification clean");
        else
            $display("pixel_tint_and_row_mirror verification failed");
        $finish;
    end

endmodule
